// ===== rtl/bwr_pkg.sv =====
// Shared types, codes and a helper function for the box wall reflection block.
`timescale 1ns / 1ps
package bwr_pkg;

   localparam int MaxBouncesDefault = 16;
   localparam int FracBitsDefault   = 16;

   // configuration register indexes
   localparam logic [2:0] REG_WALL_MODE   = 3'd0;
   localparam logic [2:0] REG_BOX_LEN_X   = 3'd1;
   localparam logic [2:0] REG_BOX_LEN_Y   = 3'd2;
   localparam logic [2:0] REG_BOX_LEN_Z   = 3'd3;
   localparam logic [2:0] REG_BACK_MARGIN = 3'd4;

   // wall modes
   localparam logic [1:0] MODE_BOUNCE   = 2'd0;
   localparam logic [1:0] MODE_SPECULAR = 2'd1;
   localparam logic [1:0] MODE_Z_ONLY   = 2'd2;

   // wall codes
   localparam logic [2:0] WALL_NONE   = 3'd0;
   localparam logic [2:0] WALL_X_LOW  = 3'd1;
   localparam logic [2:0] WALL_X_HIGH = 3'd2;
   localparam logic [2:0] WALL_Y_LOW  = 3'd3;
   localparam logic [2:0] WALL_Y_HIGH = 3'd4;
   localparam logic [2:0] WALL_Z_LOW  = 3'd5;
   localparam logic [2:0] WALL_Z_HIGH = 3'd6;

   typedef struct packed {
      logic        done;
      logic [30:0] quot;
   } bwr_div_stat_type;

   typedef struct packed {
      logic load;
      logic subtract;
   } bwr_step_ctl_type;

   // negate, saturating the most negative value
   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == 32'sh8000_0000) r = 32'sh7FFF_FFFF;
      else r = -v;
      return r;
   endfunction

endpackage

// ===== rtl/bwr_if.sv =====
// Valid/ready channel interfaces for particle words and result words.
`timescale 1ns / 1ps
interface bwr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface bwr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;
   logic [2:0]         last_wall;
   logic [4:0]         bounce_count;
   logic               limit_hit;
   modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                   new_vel_z, last_wall, bounce_count, limit_hit, input ready);
   modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                 new_vel_z, last_wall, bounce_count, limit_hit, output ready);
endinterface

// ===== rtl/bwr_div.sv =====
// Iterative restoring divider for clamped back-times, one quotient bit a cycle.
`timescale 1ns / 1ps
module bwr_div #(
   parameter int FRAC_BITS = bwr_pkg::FracBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               num,
   input  logic [31:0]               den,
   output bwr_pkg::bwr_div_stat_type stat
);
   localparam int RW = (32 + FRAC_BITS > 63) ? 32 + FRAC_BITS + 1 : 64;

   logic [RW-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [30:0]   quo_ff, quo_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [RW-1:0] num_ext, lim_ext;

   assign num_ext = RW'({num, {FRAC_BITS{1'b0}}});
   assign lim_ext = RW'(den) << 31;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         if (num_ext >= lim_ext) begin
            // quotient would reach 2^31 or more: clamp
            quo_in  = 31'h7FFF_FFFF;
            done_in = 1'b1;
         end else begin
            rem_in  = num_ext;
            dsh_in  = RW'(den) << 30;
            quo_in  = '0;
            cnt_in  = 5'd30;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in         = rem_ff - dsh_ff;
            quo_in[cnt_ff] = 1'b1;
         end
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = quo_ff;
endmodule

// ===== rtl/bwr_step.sv =====
// Shared multiplier with floor shift and saturating position update.
`timescale 1ns / 1ps
module bwr_step #(
   parameter int FRAC_BITS = bwr_pkg::FracBitsDefault
) (
   input  logic                      clock,
   input  bwr_pkg::bwr_step_ctl_type ctl,
   input  logic [31:0]               time_val,
   input  logic signed [31:0]        vel,
   input  logic signed [31:0]        pos,
   output logic signed [31:0]        pos_out
);
   logic signed [64:0] prod_ff, prod_in;
   logic               sub_ff;
   logic signed [64:0] shifted;
   logic signed [65:0] sum;

   assign prod_in = $signed({1'b0, time_val}) * vel;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff <= prod_in;
         sub_ff  <= ctl.subtract;
      end
   end

   // arithmetic shift rounds toward minus infinity
   assign shifted = prod_ff >>> FRAC_BITS;
   assign sum = sub_ff ? (66'(pos) - 66'(shifted)) : (66'(pos) + 66'(shifted));

   always_comb begin
      if (sum > 66'sh7FFF_FFFF) pos_out = 32'sh7FFF_FFFF;
      else if (sum < -66'sh8000_0000) pos_out = 32'sh8000_0000;
      else pos_out = sum[31:0];
   end
endmodule

// ===== rtl/box_wall_reflection.sv =====
// Top level: sequencer folding one particle back into the box.
//
//   channel | dir | handshake        | contents
//   req_bus | in  | valid/ready      | pos_x/y/z, vel_x/y/z (Q16.16)
//   rsp_bus | out | valid/ready      | new pos/vel, last_wall, bounce_count, limit_hit
//   csr_*   | in  | write enable     | wall_mode, box lengths, back_margin
//
// One word at a time: ready only while idle. Each pass runs a check step, one
// axis step per checked axis, a bit-serial division for each of up to 3 wall
// candidates, 6 shared multiplies (a multiply and an add step each) and one
// reflect step; a particle inside the box goes from check straight to done.
// Synchronous reset clears the sequencer and loads the register defaults.
// A result waits in its registers until rsp_bus.ready is seen.
`timescale 1ns / 1ps
module box_wall_reflection #(
   parameter int MAX_BOUNCES = bwr_pkg::MaxBouncesDefault,
   parameter int FRAC_BITS   = bwr_pkg::FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   bwr_req_if.sink     req_bus,
   bwr_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   localparam int PW = $clog2(MAX_BOUNCES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_AXIS  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_REFL  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // configuration
   logic [1:0]  mode_ff;
   logic [30:0] len_ff [3];
   logic [15:0] margin_ff;

   // particle state
   logic [2:0]         state_ff, state_in;
   logic signed [31:0] p_ff [3];
   logic signed [31:0] p_in [3];
   logic signed [31:0] v_ff [3];
   logic signed [31:0] v_in [3];
   logic [30:0]        st_ff, st_in;
   logic [2:0]         wall_ff, wall_in;
   logic [PW-1:0]      pass_ff, pass_in;
   logic               limit_ff, limit_in;
   logic [1:0]         axis_ff, axis_in;
   logic               back_ff, back_in;

   logic z_only, specular, outside;
   logic signed [31:0] pa, va;
   logic signed [32:0] over;
   logic lo, hi, cand;
   logic [31:0] div_num, div_den, t_back;
   logic div_start;
   bwr_pkg::bwr_div_stat_type div_stat;
   bwr_pkg::bwr_step_ctl_type step_ctl;
   logic signed [31:0] step_pos;

   assign z_only   = (mode_ff == bwr_pkg::MODE_Z_ONLY);
   assign specular = (mode_ff == bwr_pkg::MODE_SPECULAR);

   // out of box on any checked axis
   always_comb begin
      outside = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if ((!z_only || a == 2) &&
             (p_ff[a] < 0 || 33'(p_ff[a]) > $signed({2'b00, len_ff[a]})))
            outside = 1'b1;
      end
   end

   // wall candidate for the current axis
   assign pa   = p_ff[axis_ff];
   assign va   = v_ff[axis_ff];
   assign over = 33'(pa) - $signed({2'b00, len_ff[axis_ff]});
   assign lo   = pa < 0;
   assign hi   = over > 0;
   // back-time is positive only where distance and velocity agree in sign
   assign cand = (va != 0) && ((lo && va < 0) || (hi && va > 0));
   assign div_num = lo ? 32'(-33'(pa)) : over[31:0];
   assign div_den = va[31] ? 32'(-33'(va)) : 32'(va);
   assign div_start = (state_ff == S_AXIS) && cand;
   assign t_back = 32'(st_ff) + 32'(margin_ff);

   bwr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat)
   );

   assign step_ctl.load     = (state_ff == S_MUL);
   assign step_ctl.subtract = back_ff;

   bwr_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clock    (clock),
      .ctl      (step_ctl),
      .time_val (back_ff ? t_back : {1'b0, st_ff}),
      .vel      (v_ff[axis_ff]),
      .pos      (p_ff[axis_ff]),
      .pos_out  (step_pos)
   );

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      v_in     = v_ff;
      st_in    = st_ff;
      wall_in  = wall_ff;
      pass_in  = pass_ff;
      limit_in = limit_ff;
      axis_in  = axis_ff;
      back_in  = back_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               p_in     = '{req_bus.pos_x, req_bus.pos_y, req_bus.pos_z};
               v_in     = '{req_bus.vel_x, req_bus.vel_y, req_bus.vel_z};
               wall_in  = bwr_pkg::WALL_NONE;
               pass_in  = '0;
               limit_in = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!outside) begin
               state_in = S_DONE;
            end else if (pass_ff >= PW'(MAX_BOUNCES)) begin
               limit_in = 1'b1;
               state_in = S_DONE;
            end else begin
               st_in    = '0;
               axis_in  = z_only ? 2'd2 : 2'd0;
               state_in = S_AXIS;
            end
         end
         S_AXIS, S_DIV: begin
            if (state_ff == S_AXIS && cand) begin
               state_in = S_DIV;
            end else if (state_ff == S_AXIS || div_stat.done) begin
               // keep the first largest back-time
               if (state_ff == S_DIV && div_stat.quot > st_ff) begin
                  st_in   = div_stat.quot;
                  wall_in = {axis_ff, 1'b0} + (lo ? 3'd1 : 3'd2);
               end
               if (axis_ff == 2'd2) begin
                  axis_in  = 2'd0;
                  back_in  = 1'b1;
                  state_in = S_MUL;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_AXIS;
               end
            end
         end
         S_MUL: state_in = S_ADD;
         S_ADD: begin
            p_in[axis_ff] = step_pos;
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               if (back_ff) begin
                  state_in = S_REFL;
               end else begin
                  pass_in  = pass_ff + PW'(1);
                  state_in = S_CHECK;
               end
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_REFL: begin
            if (specular) begin
               case (wall_ff) inside
                  bwr_pkg::WALL_X_LOW, bwr_pkg::WALL_X_HIGH:
                     v_in[0] = bwr_pkg::neg_sat(v_ff[0]);
                  bwr_pkg::WALL_Y_LOW, bwr_pkg::WALL_Y_HIGH:
                     v_in[1] = bwr_pkg::neg_sat(v_ff[1]);
                  bwr_pkg::WALL_Z_LOW, bwr_pkg::WALL_Z_HIGH:
                     v_in[2] = bwr_pkg::neg_sat(v_ff[2]);
                  default: ;
               endcase
            end else begin
               for (int a = 0; a < 3; a++) v_in[a] = bwr_pkg::neg_sat(v_ff[a]);
            end
            back_in  = 1'b0;
            state_in = S_MUL;
         end
         S_DONE: begin
            if (rsp_bus.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= bwr_pkg::MODE_BOUNCE;
         len_ff    <= '{31'd65536, 31'd65536, 31'd65536};
         margin_ff <= 16'd1;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               bwr_pkg::REG_WALL_MODE:   mode_ff   <= csr_wdata[1:0];
               bwr_pkg::REG_BOX_LEN_X:   len_ff[0] <= csr_wdata;
               bwr_pkg::REG_BOX_LEN_Y:   len_ff[1] <= csr_wdata;
               bwr_pkg::REG_BOX_LEN_Z:   len_ff[2] <= csr_wdata;
               bwr_pkg::REG_BACK_MARGIN: margin_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      p_ff     <= p_in;
      v_ff     <= v_in;
      st_ff    <= st_in;
      wall_ff  <= wall_in;
      pass_ff  <= pass_in;
      limit_ff <= limit_in;
      axis_ff  <= axis_in;
      back_ff  <= back_in;
   end

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = (state_ff == S_DONE);
   assign rsp_bus.new_pos_x    = p_ff[0];
   assign rsp_bus.new_pos_y    = p_ff[1];
   assign rsp_bus.new_pos_z    = p_ff[2];
   assign rsp_bus.new_vel_x    = v_ff[0];
   assign rsp_bus.new_vel_y    = v_ff[1];
   assign rsp_bus.new_vel_z    = v_ff[2];
   assign rsp_bus.last_wall    = wall_ff;
   assign rsp_bus.bounce_count = 5'(pass_ff);
   assign rsp_bus.limit_hit    = limit_ff;
endmodule

// ===== tb/bwr_tb_if.sv =====
// Testbench types for particle words and expected result words.
`timescale 1ns / 1ps
package bwr_tb_pkg;

   typedef struct {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] vel_x, vel_y, vel_z;
   } particle_word_type;

   typedef struct {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic signed [31:0] vel_x, vel_y, vel_z;
      logic [2:0]         wall;
      logic [4:0]         bounces;
      logic               limit;
   } fold_word_type;

endpackage

// ===== tb/bwr_checker.sv =====
// Checker: watches both channels, folds each particle word and compares results.
`timescale 1ns / 1ps
module bwr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z,
   input  logic signed [31:0] in_vel_x, in_vel_y, in_vel_z,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z,
   input  logic signed [31:0] out_vel_x, out_vel_y, out_vel_z,
   input  logic [2:0]  out_wall,
   input  logic [4:0]  out_bounces,
   input  logic        out_limit,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam int MaxPasses = bwr_pkg::MaxBouncesDefault;
   localparam int Frac = bwr_pkg::FracBitsDefault;

   logic [1:0]  mode_q;
   longint      len_q [3];
   longint      margin_q;
   bwr_tb_pkg::fold_word_type folds_due [$];

   assign pending = folds_due.size();

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_shift(longint x);
      return x >>> Frac;
   endfunction

   function automatic logic is_out(longint p[3], logic z_only);
      for (int a = (z_only ? 2 : 0); a < 3; a++)
         if (p[a] < 0 || p[a] > len_q[a]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bwr_tb_pkg::fold_word_type fold_particle(
      bwr_tb_pkg::particle_word_type w);
      bwr_tb_pkg::fold_word_type r;
      longint p[3], v[3], st, t, q;
      logic z_only, spec;
      int wall, passes, lim, a;
      z_only = (mode_q == bwr_pkg::MODE_Z_ONLY);
      spec = (mode_q == bwr_pkg::MODE_SPECULAR);
      wall = 0; passes = 0; lim = 0;
      p[0] = w.pos_x; p[1] = w.pos_y; p[2] = w.pos_z;
      v[0] = w.vel_x; v[1] = w.vel_y; v[2] = w.vel_z;
      while (is_out(p, z_only)) begin
         if (passes >= MaxPasses) begin
            lim = 1;
            break;
         end
         st = 0;
         for (a = (z_only ? 2 : 0); a < 3; a++) begin
            if (v[a] == 0) continue;
            if (p[a] < 0) begin
               q = (p[a] <<< Frac) / v[a];
               if (q > 64'sd2147483647) q = 64'sd2147483647;
               if (q > st) begin st = q; wall = 2 * a + 1; end
            end
            if (p[a] > len_q[a]) begin
               q = ((p[a] - len_q[a]) <<< Frac) / v[a];
               if (q > 64'sd2147483647) q = 64'sd2147483647;
               if (q > st) begin st = q; wall = 2 * a + 2; end
            end
         end
         t = st + margin_q;
         for (a = 0; a < 3; a++) p[a] = clip32(p[a] - floor_shift(t * v[a]));
         if (spec) begin
            if (wall >= 1 && wall <= 6) v[(wall - 1) / 2] = clip32(-v[(wall - 1) / 2]);
         end else begin
            for (a = 0; a < 3; a++) v[a] = clip32(-v[a]);
         end
         for (a = 0; a < 3; a++) p[a] = clip32(p[a] + floor_shift(v[a] * st));
         passes++;
      end
      r.pos_x = p[0]; r.pos_y = p[1]; r.pos_z = p[2];
      r.vel_x = v[0]; r.vel_y = v[1]; r.vel_z = v[2];
      r.wall = wall[2:0];
      r.bounces = passes[4:0];
      r.limit = lim[0];
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      bwr_tb_pkg::particle_word_type w;
      bwr_tb_pkg::fold_word_type e;
      if (reset) begin
         mode_q <= bwr_pkg::MODE_BOUNCE;
         len_q[0] <= 65536; len_q[1] <= 65536; len_q[2] <= 65536;
         margin_q <= 1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               bwr_pkg::REG_WALL_MODE: mode_q <= csr_wdata[1:0];
               bwr_pkg::REG_BOX_LEN_X: len_q[0] <= csr_wdata;
               bwr_pkg::REG_BOX_LEN_Y: len_q[1] <= csr_wdata;
               bwr_pkg::REG_BOX_LEN_Z: len_q[2] <= csr_wdata;
               bwr_pkg::REG_BACK_MARGIN: margin_q <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            w.pos_x = in_pos_x; w.pos_y = in_pos_y; w.pos_z = in_pos_z;
            w.vel_x = in_vel_x; w.vel_y = in_vel_y; w.vel_z = in_vel_z;
            folds_due.push_back(fold_particle(w));
         end
         if (rsp_valid && rsp_ready) begin
            if (folds_due.size() == 0) begin
               $display("unexpected result word at %0t", $realtime);
               fail_count++;
            end else begin
               e = folds_due.pop_front();
               if (out_pos_x !== e.pos_x) report_mismatch("new_pos_x", out_pos_x, e.pos_x);
               if (out_pos_y !== e.pos_y) report_mismatch("new_pos_y", out_pos_y, e.pos_y);
               if (out_pos_z !== e.pos_z) report_mismatch("new_pos_z", out_pos_z, e.pos_z);
               if (out_vel_x !== e.vel_x) report_mismatch("new_vel_x", out_vel_x, e.vel_x);
               if (out_vel_y !== e.vel_y) report_mismatch("new_vel_y", out_vel_y, e.vel_y);
               if (out_vel_z !== e.vel_z) report_mismatch("new_vel_z", out_vel_z, e.vel_z);
               if (out_wall !== e.wall) report_mismatch("last_wall", out_wall, e.wall);
               if (out_bounces !== e.bounces)
                  report_mismatch("bounce_count", out_bounces, e.bounces);
               if (out_limit !== e.limit) report_mismatch("limit_hit", out_limit, e.limit);
            end
         end
      end
   end

endmodule

// ===== tb/box_wall_reflection_tb.sv =====
// Top of the box wall reflection testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module box_wall_reflection_tb;

   localparam int RandomWords = 1500;
   localparam logic [2:0] RegSpare  = 3'd7;   // index past the register list
   localparam logic [1:0] ModeSpare = 2'd3;   // unused wall mode

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [30:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          stall_hold;   // long receiver hold-off, counted down in cycles

   bwr_req_if req_bus ();
   bwr_rsp_if rsp_bus ();

   box_wall_reflection i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bwr_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready),
      .in_pos_x(req_bus.pos_x), .in_pos_y(req_bus.pos_y), .in_pos_z(req_bus.pos_z),
      .in_vel_x(req_bus.vel_x), .in_vel_y(req_bus.vel_y), .in_vel_z(req_bus.vel_z),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
      .out_pos_x(rsp_bus.new_pos_x), .out_pos_y(rsp_bus.new_pos_y),
      .out_pos_z(rsp_bus.new_pos_z), .out_vel_x(rsp_bus.new_vel_x),
      .out_vel_y(rsp_bus.new_vel_y), .out_vel_z(rsp_bus.new_vel_z),
      .out_wall(rsp_bus.last_wall), .out_bounces(rsp_bus.bounce_count),
      .out_limit(rsp_bus.limit_hit),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   // Pick a coordinate: mostly near the box, sometimes anywhere in range.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 131072);
         2: return -$urandom_range(0, 65536);
         3: return 65536 + $urandom_range(0, 65536);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   function automatic logic [31:0] pick_speed();
      case ($urandom_range(0, 6))
         0: return $urandom();
         1: return 0;
         2: return 32'h8000_0000;
         default: return $signed($urandom_range(0, 262144)) - 131072;
      endcase
   endfunction

   // Offer one particle word after a random gap; hold until accepted.
   // Valid stays high after acceptance so the next word can follow at once.
   task automatic send_word(logic [31:0] px, py, pz, vx, vy, vz);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pos_x <= px; req_bus.pos_y <= py; req_bus.pos_z <= pz;
      req_bus.vel_x <= vx; req_bus.vel_y <= vy; req_bus.vel_z <= vz;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_random();
      send_word(pick_coord(), pick_coord(), pick_coord(),
                pick_speed(), pick_speed(), pick_speed());
   endtask

   // Drop valid, drain the block, then let it settle before a register write.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: a random stall after each word, plus one long hold-off.
   initial begin
      rsp_bus.ready = 1'b0;
      stall_hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.ready && rsp_bus.valid) begin
            rsp_bus.ready <= 1'b0;
            stall_hold = $urandom_range(0, 4);
         end else if (!rsp_bus.ready) begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #400ms;
      $display("** box_wall_reflection: FAILED **");
      $finish;
   end

   initial begin
      logic [31:0] cfg_val;
      req_bus.valid = 1'b0;
      req_bus.pos_x = 0; req_bus.pos_y = 0; req_bus.pos_z = 0;
      req_bus.vel_x = 0; req_bus.vel_y = 0; req_bus.vel_z = 0;
      csr_we = 1'b0; csr_index = bwr_pkg::REG_WALL_MODE; csr_wdata = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: inside, each wall, zero and extreme velocities
      send_word(32'h8000, 32'h8000, 32'h8000, 0, 0, 0);
      send_word(-32'sd100, 32'h8000, 32'h8000, -32'sd65536, 0, 0);
      send_word(32'h18000, 32'h8000, 32'h8000, 32'sd65536, 0, 0);
      send_word(32'h8000, -32'sd100, 32'h8000, 0, -32'sd65536, 0);
      send_word(32'h8000, 32'h18000, 32'h8000, 0, 32'sd65536, 0);
      send_word(32'h8000, 32'h8000, -32'sd100, 0, 0, -32'sd65536);
      send_word(32'h8000, 32'h8000, 32'h18000, 0, 0, 32'sd65536);
      send_word(-32'sd100, 32'h8000, 32'h8000, 0, 0, 0);          // no candidate
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, -1, 1);
      send_word(-32'sd1, -32'sd1, -32'sd1, -32'sd3, 32'sd5, -32'sd7);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // pressure: receiver holds off while the sender keeps offering
      stall_hold = 400;
      for (int i = 0; i < 6; i++) send_random();
      // sender pause until every result has come
      drain();

      // phases through all modes and register extremes
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: cfg_val = 32'(bwr_pkg::MODE_SPECULAR);
            1: cfg_val = 32'(bwr_pkg::MODE_Z_ONLY);
            2: cfg_val = 32'(ModeSpare);
            default: cfg_val = $urandom_range(0, 2);
         endcase
         write_reg(bwr_pkg::REG_WALL_MODE, cfg_val[30:0]);
         write_reg(bwr_pkg::REG_BOX_LEN_X, ph == 4 ? 31'h7FFF_FFFF : ph == 5 ? 31'd0 :
                   31'($urandom_range(1, 196608)));
         write_reg(bwr_pkg::REG_BOX_LEN_Y, ph == 4 ? 31'h7FFF_FFFF : ph == 5 ? 31'd0 :
                   31'($urandom_range(1, 196608)));
         write_reg(bwr_pkg::REG_BOX_LEN_Z, ph == 4 ? 31'h7FFF_FFFF : ph == 5 ? 31'd0 :
                   31'($urandom_range(1, 196608)));
         write_reg(bwr_pkg::REG_BACK_MARGIN, ph == 4 ? 31'd65535 : ph == 5 ? 31'd0 :
                   31'($urandom_range(0, 4096)));
         write_reg(RegSpare, 31'($urandom()));   // unused index, must be ignored
         for (int i = 0; i < RandomWords / 8; i++) send_random();
      end

      drain();
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** box_wall_reflection: PASSED **");
      end else begin
         $display("** box_wall_reflection: FAILED **");
      end
      $finish;
   end

endmodule
